// ===== hdl/cmed_pkg.sv =====
// ----------------------------------------------------------------------------
// cmed_pkg
// Shared types, constants and compare helpers for the chroma 3x3 median block.
// ----------------------------------------------------------------------------
`default_nettype none

package cmed_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 8192;
  localparam int FW_W          = 13;   // frame_width register
  localparam int FH_W          = 14;   // frame_height register
  localparam int CFG_DW        = 14;   // widest register
  localparam int OXW           = 12;   // out_x
  localparam int YW            = 13;   // row counter / out_y
  localparam int FIFO_DEPTH    = 4;    // result buffer, power of two

  localparam logic [FW_W-1:0] FW_RST = 13'd1920;
  localparam logic [FH_W-1:0] FH_RST = 14'd1080;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0] pix_t;

  // one window column, sorted low to high
  typedef struct packed {
    pix_t lo;
    pix_t md;
    pix_t hi;
  } col_t;

  // per-pixel control travelling down the pipe
  typedef struct packed {
    logic [OXW-1:0] x;
    logic [YW-1:0]  y;
    pix_t           u;
    pix_t           v;
    logic           border;
    logic           has_med;
  } meta_t;

  // one result word
  typedef struct packed {
    logic [OXW-1:0] x;
    logic [YW-1:0]  y;
    pix_t           u;
    pix_t           v;
    logic           last;
  } res_t;

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
    col_t s;
    s.lo = min3(a, b, c);
    s.hi = max3(a, b, c);
    s.md = med3(a, b, c);
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/chroma_median_3x3_filter.sv =====
// ----------------------------------------------------------------------------
// chroma_median_3x3_filter
// 3x3 median on a raster chroma stream, U and V filtered apart. Borders are
// copied through, every result word carries its column and row.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_valid / in_ready   | in_u, in_v
//  out     | out_valid / out_ready | out_x, out_y, out_u, out_v, out_last
//  cfg     | cfg_we (no wait)      | cfg_addr, cfg_wdata
//
//  One pixel word accepted per cycle while in_ready is high. A pixel's
//  words pass S1, S2 and S3 before they are written into the result buffer;
//  a border pixel on a row that also completes a median produces two
//  words, which are written together and leave one at a time on the out side.
//  in_ready comes from the result buffer fill only (two free entries), so
//  out_ready has no combinational path to the in side.
//  Sync reset clears counters, window and pipe valids; the line memory is
//  not cleared and needs no clearing pass.
//
//  Pipe: S0 accept / line read -> S1 line data, column sort, write back ->
//        S2 column reduce -> S3 median, push into buffer.
//  Line memory: one word per column, {row y-2, row y-1}, U in high bytes.
//  Read and write of the same column in one cycle (width 1) is forwarded.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_median_3x3_filter #(
  parameter int MAX_WIDTH = cmed_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_u,
  input  wire logic [7:0]                   in_v,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [cmed_pkg::OXW-1:0]          out_x,
  output logic [cmed_pkg::YW-1:0]           out_y,
  output logic [7:0]                        out_u,
  output logic [7:0]                        out_v,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic [0:0]                   cfg_addr,
  input  wire logic [cmed_pkg::CFG_DW-1:0]  cfg_wdata
);
  import cmed_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);          // column counter / line address
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = ((WW > FW_W) ? WW : FW_W) + 1;
  localparam int HCW  = FH_W + 1;
  localparam int FCW  = $clog2(FIFO_DEPTH + 1);

  // ---- configuration ------------------------------------------------------
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RST;
      fh_r <= FH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- S0: counters, border decision --------------------------------------
  logic            adv, acc;
  logic [CW-1:0]   x_r, x_nxt;
  logic [YW-1:0]   y_r, y_nxt;
  logic [CMPW-1:0] fw_ext, w_eff, x_p1;
  logic [HCW-1:0]  fh_ext, h_eff, y_p1;
  logic            last_col, last_row, border0, has_med0;

  assign acc      = in_valid && adv;
  assign in_ready = adv;

  always_comb begin
    // zero acts as one, oversize saturates
    fw_ext = CMPW'(fw_r);
    if (fw_ext == '0)                  w_eff = CMPW'(1);
    else if (fw_ext > CMPW'(MAX_WIDTH)) w_eff = CMPW'(MAX_WIDTH);
    else                               w_eff = fw_ext;

    fh_ext = HCW'(fh_r);
    if (fh_ext == '0)                   h_eff = HCW'(1);
    else if (fh_ext > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
    else                                h_eff = fh_ext;

    x_p1     = CMPW'(x_r) + CMPW'(1);
    y_p1     = HCW'(y_r) + HCW'(1);
    last_col = (x_p1 >= w_eff);
    last_row = (y_p1 >= h_eff);
    border0  = (x_r == '0) || last_col || (y_r == '0) || last_row;
    has_med0 = (x_r >= CW'(2)) && (y_r >= YW'(2));

    if (last_col) begin
      x_nxt = '0;
      y_nxt = last_row ? '0 : y_p1[YW-1:0];
    end else begin
      x_nxt = x_p1[CW-1:0];
      y_nxt = y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (acc) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
    end
  end

  // ---- line memory --------------------------------------------------------
  logic [31:0]   lmem [MAX_WIDTH];
  logic [31:0]   rd_r;
  logic          wr_en;
  logic [15:0]   s1_top, s1_mid, s1_cur;

  // S1 state
  logic          s1_vld_r;
  logic [CW-1:0] s1_x_r;
  meta_t         s1_meta_r, meta0;
  logic          fwd_r;
  logic [15:0]   fwd_top_r, fwd_mid_r;

  assign wr_en = adv && s1_vld_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_r <= lmem[x_r];
    end
    if (wr_en) begin
      lmem[s1_x_r] <= {s1_mid, s1_cur};   // row y-1 ages to y-2, current becomes y-1
    end
  end

  always_comb begin
    meta0.x       = OXW'(x_r);
    meta0.y       = y_r;
    meta0.u       = in_u;
    meta0.v       = in_v;
    meta0.border  = border0;
    meta0.has_med = has_med0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r    <= x_r;
      s1_meta_r <= meta0;
      // same column being written back this cycle: memory returns old data
      fwd_r     <= s1_vld_r && (s1_x_r == x_r);
      fwd_top_r <= s1_mid;
      fwd_mid_r <= s1_cur;
    end
  end

  // ---- S1: column assembly and sort ---------------------------------------
  col_t  colu, colv;
  col_t  win_u_r [3];
  col_t  win_v_r [3];

  always_comb begin
    s1_top = fwd_r ? fwd_top_r : rd_r[31:16];
    s1_mid = fwd_r ? fwd_mid_r : rd_r[15:0];
    s1_cur = {s1_meta_r.u, s1_meta_r.v};
    colu   = sort3(s1_top[15:8], s1_mid[15:8], s1_cur[15:8]);
    colv   = sort3(s1_top[7:0],  s1_mid[7:0],  s1_cur[7:0]);
  end

  // window holds the last three sorted columns; order within a column
  // does not affect the median
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_u_r[i] <= '0;
        win_v_r[i] <= '0;
      end
    end else if (wr_en) begin
      win_u_r[0] <= win_u_r[1];
      win_u_r[1] <= win_u_r[2];
      win_u_r[2] <= colu;
      win_v_r[0] <= win_v_r[1];
      win_v_r[1] <= win_v_r[2];
      win_v_r[2] <= colv;
    end
  end

  // ---- S2 / S3 ------------------------------------------------------------
  logic  s2_vld_r, s3_vld_r;
  meta_t s2_meta_r, s3_meta_r;
  pix_t  med_u, med_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta_r <= s1_meta_r;
      s3_meta_r <= s2_meta_r;
    end
  end

  cmed_rank u_rank_u (
    .clk (clk),
    .en  (adv),
    .c0  (win_u_r[0]),
    .c1  (win_u_r[1]),
    .c2  (win_u_r[2]),
    .med (med_u)
  );

  cmed_rank u_rank_v (
    .clk (clk),
    .en  (adv),
    .c0  (win_v_r[0]),
    .c1  (win_v_r[1]),
    .c2  (win_v_r[2]),
    .med (med_v)
  );

  // ---- result words -------------------------------------------------------
  res_t           med_word, brd_word, word_a, head;
  logic           push, push_two, not_empty;
  logic [FCW-1:0] fill;

  always_comb begin
    med_word.x    = s3_meta_r.x - OXW'(1);
    med_word.y    = s3_meta_r.y - YW'(1);
    med_word.u    = med_u;
    med_word.v    = med_v;
    med_word.last = !s3_meta_r.border;

    brd_word.x    = s3_meta_r.x;
    brd_word.y    = s3_meta_r.y;
    brd_word.u    = s3_meta_r.u;
    brd_word.v    = s3_meta_r.v;
    brd_word.last = 1'b1;

    // median first, border copy after it
    word_a   = s3_meta_r.has_med ? med_word : brd_word;
    push     = adv && s3_vld_r && (s3_meta_r.has_med || s3_meta_r.border);
    push_two = s3_meta_r.has_med && s3_meta_r.border;
  end

  cmed_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_two  (push_two),
    .word_a    (word_a),
    .word_b    (brd_word),
    .pop       (out_ready),
    .head      (head),
    .not_empty (not_empty),
    .space_ok  (adv),
    .fill      (fill)
  );

  assign out_valid = not_empty;
  assign out_x     = head.x;
  assign out_y     = head.y;
  assign out_u     = head.u;
  assign out_v     = head.v;
  assign out_last  = head.last;

  // ---- assertions ---------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= FCW'(FIFO_DEPTH))
    else $error("result buffer overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_two) |-> (fill <= FCW'(FIFO_DEPTH - 2)))
    else $error("double push without room");

  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && s1_vld_r && (s1_x_r == x_r)) |=> fwd_r)
    else $error("line write/read collision not forwarded");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    CMPW'(x_r) < CMPW'(MAX_WIDTH))
    else $error("column counter beyond line memory");

endmodule

`default_nettype wire

// ===== hdl/cmed_rank.sv =====
// ----------------------------------------------------------------------------
// cmed_rank
// Median of nine from three sorted columns: max of lows, median of middles,
// min of highs, registered, then median of those three.
// ----------------------------------------------------------------------------
`default_nettype none

module cmed_rank (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire cmed_pkg::col_t c0,
  input  wire cmed_pkg::col_t c1,
  input  wire cmed_pkg::col_t c2,
  output cmed_pkg::pix_t     med
);
  import cmed_pkg::*;

  pix_t lo_r, md_r, hi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r <= max3(c0.lo, c1.lo, c2.lo);
      md_r <= med3(c0.md, c1.md, c2.md);
      hi_r <= min3(c0.hi, c1.hi, c2.hi);
    end
  end

  assign med = med3(lo_r, md_r, hi_r);

endmodule

`default_nettype wire

// ===== hdl/cmed_ofifo.sv =====
// ----------------------------------------------------------------------------
// cmed_ofifo
// Small result buffer. Takes one or two words a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module cmed_ofifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire logic           push_two,
  input  wire cmed_pkg::res_t word_a,
  input  wire cmed_pkg::res_t word_b,
  input  wire logic           pop,
  output cmed_pkg::res_t      head,
  output logic                not_empty,
  output logic                space_ok,
  output logic [$clog2(cmed_pkg::FIFO_DEPTH+1)-1:0] fill
);
  import cmed_pkg::*;

  localparam int PTRW = $clog2(FIFO_DEPTH);
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  res_t            buf_r [FIFO_DEPTH];
  logic [PTRW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [CNTW-1:0] n_in;
  logic            do_pop;

  assign do_pop = pop && (cnt_r != '0);
  assign n_in   = !push ? CNTW'(0) : (push_two ? CNTW'(2) : CNTW'(1));

  always_comb begin
    wp_nxt  = wp_r + PTRW'(n_in);
    rp_nxt  = do_pop ? rp_r + PTRW'(1) : rp_r;
    cnt_nxt = cnt_r + n_in - (do_pop ? CNTW'(1) : CNTW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= word_a;
    end
    if (push && push_two) begin
      buf_r[wp_r + PTRW'(1)] <= word_b;
    end
  end

  assign head      = buf_r[rp_r];
  assign not_empty = (cnt_r != '0);
  assign space_ok  = (cnt_r <= CNTW'(FIFO_DEPTH - 2));
  assign fill      = cnt_r;

endmodule

`default_nettype wire

// ===== sim/cmed_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmed_checker
// Watches the pixel, result and register ports of the chroma 3x3 median
// block, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------

module cmed_checker
  import cmed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_u,
  input  logic [7:0]        in_v,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [OXW-1:0]    out_x,
  input  logic [YW-1:0]     out_y,
  input  logic [7:0]        out_u,
  input  logic [7:0]        out_v,
  input  logic              out_last,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                due_count,
  output int                pos_col,
  output int                pos_row
);

  localparam int MAX_COLS = MAX_WIDTH_DEF;

  logic [FW_W-1:0] width_reg;
  logic [FH_W-1:0] height_reg;
  logic [15:0]     row_above2 [MAX_COLS];
  logic [15:0]     row_above1 [MAX_COLS];
  logic [47:0]     win_left;
  logic [47:0]     win_centre;
  int              col_cnt;
  int              row_cnt;
  res_t            due_words [$];

  initial begin
    fail_count = 0;
    due_count  = 0;
    pos_col    = 0;
    pos_row    = 0;
  end

  function automatic logic [7:0] mid_of_nine(input logic [8:0][7:0] s);
    int lower, same;
    for (int i = 0; i < 9; i++) begin
      lower = 0;
      same  = 0;
      for (int j = 0; j < 9; j++) begin
        if (s[j] < s[i]) lower++;
        else if (s[j] == s[i]) same++;
      end
      if (lower <= 4 && lower + same >= 5) return s[i];
    end
    return s[0];
  endfunction

  // one accepted pixel: queue the median word for (x-1,y-1) if x and y are
  // both at least 2, then the copy of the pixel itself if it sits on the frame edge
  task automatic filter_pixel(input logic [7:0] u, input logic [7:0] v);
    int               w, h, x, y;
    logic [15:0]      top_px, mid_px;
    logic [47:0]      col_now, col_pick;
    logic [8:0][7:0]  us, vs;
    logic             on_border;
    res_t             word;
    w = int'(width_reg);
    h = int'(height_reg);
    if (w == 0) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (h == 0) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    x = col_cnt;
    y = row_cnt;
    top_px  = row_above2[x];
    mid_px  = row_above1[x];
    col_now = {top_px, mid_px, u, v};
    on_border = (x == 0) || (x + 1 >= w) || (y == 0) || (y + 1 >= h);

    if (x >= 2 && y >= 2) begin
      for (int c = 0; c < 3; c++) begin
        col_pick = (c == 0) ? win_left : (c == 1) ? win_centre : col_now;
        for (int r = 0; r < 3; r++) begin
          us[c * 3 + r] = col_pick[47 - 16 * r -: 8];
          vs[c * 3 + r] = col_pick[39 - 16 * r -: 8];
        end
      end
      word.x    = OXW'(x - 1);
      word.y    = YW'(y - 1);
      word.u    = mid_of_nine(us);
      word.v    = mid_of_nine(vs);
      word.last = !on_border;
      due_words.push_back(word);
    end
    if (on_border) begin
      word.x    = OXW'(x);
      word.y    = YW'(y);
      word.u    = u;
      word.v    = v;
      word.last = 1'b1;
      due_words.push_back(word);
    end

    win_left      = win_centre;
    win_centre    = col_now;
    row_above2[x] = mid_px;
    row_above1[x] = {u, v};

    if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  task automatic log_failure(input string what, input res_t want, input res_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: want x=%0d y=%0d u=%0d v=%0d last=%0b", $realtime, what,
               want.x, want.y, want.u, want.v, want.last);
      $display("%0t %s: got  x=%0d y=%0d u=%0d v=%0d last=%0b", $realtime, what,
               got.x, got.y, got.u, got.v, got.last);
    end
  endtask

  task automatic check_word(input res_t got);
    res_t want;
    if (due_words.size() == 0) begin
      log_failure("unexpected result word", '0, got);
    end else begin
      want = due_words.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.u !== want.u ||
          got.v !== want.v || got.last !== want.last)
        log_failure("result word mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = FW_RST;
      height_reg = FH_RST;
      win_left   = '0;
      win_centre = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      due_words.delete();
      for (int i = 0; i < MAX_COLS; i++) begin
        row_above2[i] = '0;
        row_above1[i] = '0;
      end
    end else begin
      if (out_valid && out_ready)
        check_word({out_x, out_y, out_u, out_v, out_last});
      if (cfg_we) begin
        if (cfg_addr == REG_FRAME_WIDTH) width_reg = cfg_wdata[FW_W-1:0];
        else height_reg = cfg_wdata[FH_W-1:0];
      end
      if (in_valid && in_ready)
        filter_pixel(in_u, in_v);
    end
    due_count <= due_words.size();
    pos_col   <= col_cnt;
    pos_row   <= row_cnt;
  end

endmodule

// ===== sim/chroma_median_3x3_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_median_3x3_filter_test
// Drives pixel words into the chroma median block under random source gaps
// and sink stalls, reprograms the frame size between phases and mid-frame,
// and leaves all prediction and comparison to cmed_checker.
// ----------------------------------------------------------------------------

module chroma_median_3x3_filter_test;
  import cmed_pkg::*;

  localparam int WATCHDOG_LIMIT = 500_000;
  localparam int SETTLE_CYCLES  = 10;   // pipe is four deep, leave some slack
  localparam int RANDOM_PIXELS  = 950;
  localparam int DIRECTED_N     = 9;

  // fixed words for the directed frames: extremes and crossed U/V values
  localparam logic [15:0] DIRECTED_PX [DIRECTED_N] = '{
    16'h00FF, 16'hFF00, 16'h807F, 16'hFFFF, 16'h0000,
    16'h01FE, 16'h7F80, 16'hAA55, 16'h55AA
  };

  typedef enum int { SEND_STEADY, SEND_SHORT_GAPS, SEND_SPARSE } send_style_t;
  typedef enum int { SINK_EAGER, SINK_LIGHT, SINK_BUSY, SINK_PERIODIC } sink_style_t;
  typedef enum int { PAT_UNIFORM, PAT_FLAT, PAT_SALT, PAT_BINARY } pattern_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [7:0]        in_u      = '0;
  logic [7:0]        in_v      = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [OXW-1:0]    out_x;
  logic [YW-1:0]     out_y;
  logic [7:0]        out_u;
  logic [7:0]        out_v;
  logic              out_last;
  logic              cfg_we    = 1'b0;
  logic [0:0]        cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int fail_count, due_count, pos_col, pos_row;

  // stimulus knobs, changed per phase
  send_style_t sender_style = SEND_STEADY;
  sink_style_t sink_style   = SINK_EAGER;
  pattern_t    pattern      = PAT_UNIFORM;
  logic [7:0]  base_u       = 8'd128;
  logic [7:0]  base_v       = 8'd128;
  int          burst_left   = 0;
  bit          hold_request = 1'b0;

  // frame size as the block sees it after zero and oversize handling
  int eff_w = 1920;
  int eff_h = 1080;

  int unsigned watchdog_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chroma_median_3x3_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_u      (in_u),
    .in_v      (in_v),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_u     (out_u),
    .out_v     (out_v),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  cmed_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_u       (in_u),
    .in_v       (in_v),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_u      (out_u),
    .out_v      (out_v),
    .out_last   (out_last),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .due_count  (due_count),
    .pos_col    (pos_col),
    .pos_row    (pos_row)
  );

  // Result sink. Stalls follow sink_style; a hold request from the stimulus
  // side holds out_ready low until a randomly drawn hold runs out, so the
  // result buffer fills and in_ready drops while pixels are still being offered.
  initial begin : result_sink
    int          hold_left;
    int unsigned tick;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = $urandom_range(300, 150);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (sink_style)
          SINK_EAGER: out_ready <= 1'b1;
          SINK_LIGHT: out_ready <= ($urandom_range(99) < 75);
          SINK_BUSY:  out_ready <= ($urandom_range(99) < 30);
          default:    out_ready <= ((tick % 7) > 2);
        endcase
      end
    end
  end

  // Run limit: far above the slowest legal run (two words per pixel, busy
  // sink, sparse source and every long hold added up).
  initial begin : watchdog
    watchdog_cycles = 0;
    while (watchdog_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      watchdog_cycles++;
    end
    $display("chroma_median_3x3_filter_test NOT OK");
    $finish;
  end

  // Next pixel word from the phase pattern. Flat and salt-and-pepper
  // content give medians that differ from plain copies.
  function automatic logic [15:0] chroma_sample();
    logic [7:0] u, v;
    case (pattern)
      PAT_FLAT: begin
        u = base_u + 8'($urandom_range(6)) - 8'd3;
        v = base_v + 8'($urandom_range(6)) - 8'd3;
      end
      PAT_SALT: begin
        u = ($urandom_range(4) == 0) ? {8{1'($urandom_range(1))}} : base_u;
        v = ($urandom_range(4) == 0) ? {8{1'($urandom_range(1))}} : base_v;
      end
      PAT_BINARY: begin
        u = {8{1'($urandom_range(1))}};
        v = {8{1'($urandom_range(1))}};
      end
      default: begin
        u = 8'($urandom);
        v = 8'($urandom);
      end
    endcase
    return {u, v};
  endfunction

  // Pixels left until the counters come back to column 0 of row 0,
  // starting from where the checker says the block stands now.
  function automatic int pixels_to_frame_end();
    int cx, cy, n;
    cx = pos_col;
    cy = pos_row;
    n  = 0;
    do begin
      n++;
      if (cx + 1 >= eff_w) begin
        cx = 0;
        cy = (cy + 1 >= eff_h) ? 0 : cy + 1;
      end else begin
        cx++;
      end
    end while (cx != 0 || cy != 0);
    return n;
  endfunction

  // Only called with the block idle. cfg_we drops again after each write,
  // so back-to-back writes never touch it twice in one step.
  task automatic set_register(input cfg_reg_t idx, input logic [CFG_DW-1:0] val);
    int n;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      n     = int'(val[FW_W-1:0]);
      eff_w = (n == 0) ? 1 : (n > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : n;
    end else begin
      n     = int'(val[FH_W-1:0]);
      eff_h = (n == 0) ? 1 : (n > MAX_HEIGHT) ? MAX_HEIGHT : n;
    end
  endtask

  // Offer one pixel word and return at the edge that accepts it. The source
  // runs in bursts; a gap only opens at the start of a new burst.
  task automatic offer_pixel(input logic [15:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      case (sender_style)
        SEND_SHORT_GAPS: gap = $urandom_range(3, 0);
        SEND_SPARSE:     gap = $urandom_range(12, 1);
        default:         gap = 0;
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_u     <= px[15:8];
    in_v     <= px[7:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pixels(input int count);
    for (int i = 0; i < count; i++) offer_pixel(chroma_sample());
  endtask

  // Stop offering, wait for every due word, then let the pipe run dry
  // (interior pixels near the top-left leave nothing behind to wait for).
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int random_sent, phase, rem, k, wr, hr;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---------------------------------------------------------
    // Reset frame size first: three words on row 0, then shrink to 3x3 while
    // the column counter already stands past the new last column.
    for (int i = 0; i < 3; i++) offer_pixel(DIRECTED_PX[i]);
    settle_block();
    set_register(REG_FRAME_WIDTH, 14'd3);
    set_register(REG_FRAME_HEIGHT, 14'd3);
    rem = pixels_to_frame_end();
    for (int i = 0; i < rem; i++) offer_pixel(DIRECTED_PX[(i + 3) % DIRECTED_N]);
    settle_block();

    // zero sizes act as one: every pixel is a one-pixel frame
    set_register(REG_FRAME_WIDTH, 14'd0);
    set_register(REG_FRAME_HEIGHT, 14'd0);
    offer_pixel(16'h0000);
    offer_pixel(16'hFFFF);
    settle_block();

    // oversize saturates; spare top bit of the width write is ignored
    set_register(REG_FRAME_WIDTH, 14'h3FFF);
    set_register(REG_FRAME_HEIGHT, 14'h3FFF);
    for (int i = 0; i < 4; i++) offer_pixel(DIRECTED_PX[(i * 2) % DIRECTED_N]);
    settle_block();
    set_register(REG_FRAME_WIDTH, 14'd3);
    set_register(REG_FRAME_HEIGHT, 14'd3);
    rem = pixels_to_frame_end();
    for (int i = 0; i < rem; i++) offer_pixel(DIRECTED_PX[(i * 4 + 1) % DIRECTED_N]);
    settle_block();

    // --- random phases ----------------------------------------------------
    // Each phase starts on a frame boundary, so a wider frame always
    // rewrites both line stores before the first median reads them. Width
    // only ever shrinks mid-frame; height may move either way.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_PIXELS) begin
      if (phase == 0) begin
        // steady source into a long sink hold: buffer fills, input stalls
        wr            = 12;
        hr            = 6;
        sender_style  = SEND_STEADY;
        sink_style    = SINK_EAGER;
        pattern       = PAT_SALT;
        hold_request  = 1'b1;
      end else begin
        case ($urandom_range(9))
          0:       wr = $urandom_range(2, 0);
          1:       wr = $urandom_range(40, 20);
          default: wr = $urandom_range(12, 3);
        endcase
        hr           = ($urandom_range(9) == 0) ? $urandom_range(2, 0) : $urandom_range(7, 3);
        sender_style = send_style_t'($urandom_range(2));
        sink_style   = sink_style_t'($urandom_range(3));
        pattern      = pattern_t'($urandom_range(3));
        if ($urandom_range(5) == 0) hold_request = 1'b1;
      end
      base_u = 8'($urandom);
      base_v = 8'($urandom);
      set_register(REG_FRAME_WIDTH, {1'($urandom_range(1)), 13'(wr)});
      set_register(REG_FRAME_HEIGHT, 14'(hr));

      rem = pixels_to_frame_end();
      if (phase != 0 && rem > 2 && $urandom_range(2) == 0) begin
        // part of a frame, then a size change with the counters mid-frame
        k = $urandom_range(rem - 1, 1);
        send_pixels(k);
        random_sent += k;
        settle_block();
        set_register(REG_FRAME_WIDTH, 14'($urandom_range(eff_w, 1)));
        set_register(REG_FRAME_HEIGHT, 14'($urandom_range(8, 0)));
        rem = pixels_to_frame_end();
      end else begin
        rem = rem * $urandom_range(2, 1);   // one or two whole frames
      end
      send_pixels(rem);
      random_sent += rem;
      settle_block();
      phase++;
    end

    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fail_count == 0 && due_count == 0) begin
      $display("chroma_median_3x3_filter_test OK");
    end else begin
      $display("chroma_median_3x3_filter_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cmed_pkg.sv
hdl/cmed_rank.sv
hdl/cmed_ofifo.sv
hdl/chroma_median_3x3_filter.sv
sim/cmed_checker.sv
sim/chroma_median_3x3_filter_test.sv
